// ===== hdl/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list package
// Codes, command struct and widths shared by the sorted list cells and top.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 5;   // width of the entry_count field
   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 40;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DELETED   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_LISTED    = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_READ
   } fsm_type;

endpackage

// ===== hdl/sli_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry; compares it with the operand and takes its own, its
// neighbour's or the operand value as the list shifts.
// ----------------------------------------------------------------------------
module sli_cell
   import sli_pkg::*;
(
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic                      valid,       // entry lies below the count
   input  logic                      next_valid,  // right neighbour is valid
   input  logic                      shift_in,    // insert point lies left of this cell
   input  logic                      hit_in,      // delete match lies left of this cell
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [VALUE_W-1:0] right_value,
   input  logic signed [VALUE_W-1:0] head_value,
   output logic                      shift_out,
   output logic                      hit_out,
   output logic signed [VALUE_W-1:0] value
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      tail;

   // sorted, so "not smaller" marks a suffix of the valid entries
   assign shift_out = !valid || (entry_ff >= cmd.value);
   assign hit_out   = hit_in || (valid && (entry_ff == cmd.value));
   assign tail      = valid && !next_valid;
   assign value     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (shift_in) begin
               entry_in = left_value;
            end else if (shift_out) begin
               entry_in = cmd.value;
            end
         end
         CELL_DELETE: begin
            if (hit_out) begin
               entry_in = right_value;
            end
         end
         // read-out turns the valid part once round, head wraps to the tail
         CELL_ROTATE: begin
            entry_in = tail ? head_value : right_value;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/sorted_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// Sorted list with insert and delete
// Row of compare-and-shift cells keeping signed values in ascending order.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                               tuser        tlast
//  req      in   [31:0] value                        [1:0] mode   -
//  rsp      out  [31:0] entry_value, [36:32] count   [2:0] status last
//
//  Insert and delete finish in the cycle of acceptance; the result sits in
//  the output register the next cycle. Read-out gives one beat per cycle,
//  count beats, while the cell row rotates; no request is taken meanwhile.
//  A stalled rsp holds the row and the read-out where they are.
//  Reset empties the list at once.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
   import sli_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [31:0] value
   input  logic [MODE_W-1:0]      req_tuser,   // [1:0] mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] entry_value, [36:32] entry_count
   output logic [STATUS_W-1:0]    rsp_tuser,   // [2:0] status
   output logic                   rsp_tlast    // last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   fsm_type                   state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   cell_cmd_type              cmd;
   logic                      accept;
   logic                      out_free;
   logic                      full;
   logic                      found;
   mode_type                  mode;

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic                      cell_shift [CAPACITY];
   logic                      cell_hit   [CAPACITY];
   logic                      cell_valid [CAPACITY];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == FSM_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign mode       = mode_type'(req_tuser);
   assign full       = (count_ff >= CNT_W'(CAPACITY));
   assign found      = cell_hit[CAPACITY-1];

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic                      shift_left;
         logic                      hit_left;
         logic                      valid_right;
         logic signed [VALUE_W-1:0] value_left;
         logic signed [VALUE_W-1:0] value_right;

         assign cell_valid[i] = (count_ff > CNT_W'(i));

         if (i == 0) begin : g_first
            assign shift_left = 1'b0;
            assign hit_left   = 1'b0;
            assign value_left = cmd.value;
         end else begin : g_inner
            assign shift_left = cell_shift[i-1];
            assign hit_left   = cell_hit[i-1];
            assign value_left = cell_value[i-1];
         end

         if (i == CAPACITY - 1) begin : g_end
            assign valid_right = 1'b0;
            assign value_right = cell_value[i];
         end else begin : g_mid
            assign valid_right = cell_valid[i+1];
            assign value_right = cell_value[i+1];
         end

         sli_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .valid       (cell_valid[i]),
            .next_valid  (valid_right),
            .shift_in    (shift_left),
            .hit_in      (hit_left),
            .left_value  (value_left),
            .right_value (value_right),
            .head_value  (cell_value[0]),
            .shift_out   (cell_shift[i]),
            .hit_out     (cell_hit[i]),
            .value       (cell_value[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.op        = CELL_HOLD;
      cmd.value     = $signed(req_tdata[VALUE_W-1:0]);

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_value_in = $signed(req_tdata[VALUE_W-1:0]);
               rsp_last_in  = 1'b1;
               case (mode)
                  MODE_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                        rsp_count_in  = count_ff;
                     end else begin
                        cmd.op        = CELL_INSERT;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = ST_INSERTED;
                        rsp_count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_DELETE: begin
                     rsp_valid_in = 1'b1;
                     cmd.op       = CELL_DELETE;
                     if (found) begin
                        count_in      = count_ff - CNT_W'(1);
                        rsp_status_in = ST_DELETED;
                        rsp_count_in  = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                        rsp_count_in  = count_ff;
                     end
                  end
                  MODE_READ: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_value_in  = '0;
                        rsp_count_in  = '0;
                     end else begin
                        state_in = FSM_READ;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     // unused mode: taken, no beat
                  end
               endcase
            end
         end
         FSM_READ: begin
            if (out_free) begin
               cmd.op        = CELL_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_LISTED;
               rsp_value_in  = cell_value[0];
               rsp_count_in  = count_ff;
               rsp_last_in   = (idx_ff == count_ff - CNT_W'(1));
               idx_in        = idx_ff + CNT_W'(1);
               if (idx_ff == count_ff - CNT_W'(1)) begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VALUE_W - COUNT_W)'(0),
                        COUNT_W'(rsp_count_ff), rsp_value_ff};

endmodule

// ===== tb/sv/sorted_list_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted list checker
// Follows every accepted request and keeps a mirror of the sorted store. It
// predicts each response beat and compares it field by field with what the
// block returns. It counts mismatches and the beats still outstanding.
// ----------------------------------------------------------------------------
module sorted_list_checker
   import sli_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic [MODE_W-1:0]     req_tuser,   // [1:0] mode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] entry_value, [36:32] entry_count
   input  logic [STATUS_W-1:0]   rsp_tuser,   // [2:0] status
   input  logic                  rsp_tlast,   // last
   output int                    fail_count,
   output int                    beats_due
);

   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } list_beat_type;

   logic signed [VALUE_W-1:0] list_mirror [CAPACITY];
   int                        list_len = 0;
   list_beat_type             due_beats [$];
   int                        mismatches = 0;
   int                        due_n = 0;

   assign fail_count = mismatches;
   assign beats_due  = due_n;

   // Updates the mirror and queues the beats the block should return.
   task automatic apply_request(input mode_type mode, input logic signed [VALUE_W-1:0] v);
      int pos;
      pos = 0;
      case (mode)
         MODE_INSERT: begin
            if (list_len >= CAPACITY) begin
               due_beats.push_back('{ST_FULL, v, COUNT_W'(list_len), 1'b1});
            end else begin
               // a new value goes before equal ones: stop at first not smaller
               while (pos < list_len && list_mirror[pos] < v)
                  pos++;
               for (int i = list_len; i > pos; i--)
                  list_mirror[i] = list_mirror[i-1];
               list_mirror[pos] = v;
               list_len++;
               due_beats.push_back('{ST_INSERTED, v, COUNT_W'(list_len), 1'b1});
            end
         end
         MODE_DELETE: begin
            while (pos < list_len && list_mirror[pos] != v)
               pos++;
            if (pos >= list_len) begin
               due_beats.push_back('{ST_NOT_FOUND, v, COUNT_W'(list_len), 1'b1});
            end else begin
               for (int i = pos; i + 1 < list_len; i++)
                  list_mirror[i] = list_mirror[i+1];
               list_len--;
               due_beats.push_back('{ST_DELETED, v, COUNT_W'(list_len), 1'b1});
            end
         end
         MODE_READ: begin
            if (list_len == 0) begin
               due_beats.push_back('{ST_EMPTY, '0, '0, 1'b1});
            end else begin
               for (int i = 0; i < list_len; i++)
                  due_beats.push_back('{ST_LISTED, list_mirror[i], COUNT_W'(list_len),
                                        i == list_len - 1});
            end
         end
         default: ;   // unused mode: no state change, no beat
      endcase
   endtask

   always @(posedge clock) begin
      list_beat_type want;
      if (reset) begin
         list_len = 0;
         due_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected rsp beat: status %0d value %h count %0d last %b",
                           $realtime, rsp_tuser, rsp_tdata[VALUE_W-1:0],
                           rsp_tdata[VALUE_W+COUNT_W-1:VALUE_W], rsp_tlast);
            end else begin
               want = due_beats.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata[VALUE_W-1:0] !== want.value ||
                   rsp_tdata[VALUE_W+COUNT_W-1:VALUE_W] !== want.count ||
                   rsp_tlast !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: rsp mismatch: exp %0d %h %0d %b, got %0d %h %0d %b",
                              $realtime, want.status, want.value, want.count, want.last,
                              rsp_tuser, rsp_tdata[VALUE_W-1:0],
                              rsp_tdata[VALUE_W+COUNT_W-1:VALUE_W], rsp_tlast);
               end
            end
         end
         // a request's beats appear no earlier than the next cycle
         if (req_tvalid && req_tready)
            apply_request(mode_type'(req_tuser), req_tdata[VALUE_W-1:0]);
      end
      due_n = due_beats.size();
   end

endmodule

// ===== tb/sv/sorted_list_insert_delete_tb.sv =====
// ----------------------------------------------------------------------------
// Sorted list testbench
// Drives directed and random insert, delete and read-out requests with random
// gaps on both channels. A checker beside the block predicts every beat.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb
   import sli_pkg::*;
();

   localparam int CAPACITY = DEF_CAPACITY;
   localparam int RANDOM_ITEMS = 105;

   typedef enum {
      PH_FILL,
      PH_DRAIN,
      PH_MIXED
   } phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = MODE_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   int                    fail_count;
   int                    beats_due;
   logic                  no_idle = 1'b0;
   logic [VALUE_W-1:0]    inserted_vals [$];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   sorted_list_insert_delete #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sorted_list_checker #(.CAPACITY(CAPACITY)) list_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .beats_due  (beats_due)
   );

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_request(input mode_type mode, input logic [VALUE_W-1:0] v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = v;
      req_tuser  = mode;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
      if (mode == MODE_INSERT)
         inserted_vals.push_back(v);
   endtask

   // Extremes, small values that collide often, and full-range noise.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000 + $urandom_range(0, 2);
         1:       return 32'h7FFF_FFFF - $urandom_range(0, 2);
         2, 3:    return 32'($urandom_range(0, 8) - 4);
         default: return $urandom();
      endcase
   endfunction

   // Response side: random stall before each beat, none during no-idle phases.
   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do
            @(posedge clock);
         while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      int        sent;
      int        phase_len;
      int        pick;
      int        phase_idx;
      phase_type phase;
      mode_type  mode;
      logic [VALUE_W-1:0] v;

      sent = 0;
      phase_idx = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty store, extremes, duplicates, absent delete, unused mode
      send_request(MODE_READ,   32'h1234_5678);
      send_request(MODE_DELETE, 32'd7);
      send_request(MODE_INSERT, 32'h8000_0000);
      send_request(MODE_INSERT, 32'h7FFF_FFFF);
      send_request(MODE_INSERT, 32'h0000_0000);
      send_request(MODE_INSERT, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 32'd5);
      send_request(MODE_INSERT, 32'd5);
      send_request(MODE_INSERT, 32'd1);
      send_request(MODE_READ,   32'hFFFF_FFFF);
      send_request(MODE_DELETE, 32'd3);
      send_request(MODE_DELETE, 32'd5);
      send_request(MODE_DELETE, 32'h7FFF_FFFF);
      send_request(MODE_NONE,   32'hFFFF_FFFF);
      send_request(MODE_READ,   32'h0);
      send_request(MODE_DELETE, 32'h8000_0000);
      send_request(MODE_INSERT, 32'hFFFF_FFFF);
      send_request(MODE_DELETE, 32'hFFFF_FFFF);
      send_request(MODE_READ,   32'h0);

      // random phases; the first one is mostly inserts so that full is likely reached
      while (sent < RANDOM_ITEMS) begin
         phase     = (phase_idx == 0) ? PH_FILL : phase_type'($urandom_range(0, 2));
         phase_len = (phase_idx == 0) ? 24 : $urandom_range(8, 24);
         no_idle   = ($urandom_range(0, 3) == 0);
         phase_idx++;
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            case (phase)
               PH_FILL:  mode = pick < 75 ? MODE_INSERT : pick < 85 ? MODE_DELETE :
                                pick < 95 ? MODE_READ : MODE_NONE;
               PH_DRAIN: mode = pick < 15 ? MODE_INSERT : pick < 80 ? MODE_DELETE :
                                pick < 95 ? MODE_READ : MODE_NONE;
               default:  mode = pick < 35 ? MODE_INSERT : pick < 70 ? MODE_DELETE :
                                pick < 95 ? MODE_READ : MODE_NONE;
            endcase
            if (mode == MODE_DELETE && inserted_vals.size() > 0 && $urandom_range(0, 9) < 7)
               v = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
            else if (mode == MODE_INSERT || mode == MODE_DELETE)
               v = pick_value();
            else
               v = $urandom();
            send_request(mode, v);
            sent++;
         end
      end
      req_tvalid = 1'b0;
      no_idle = 1'b0;

      wait (beats_due == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("Verification failed");
      $finish;
   end

endmodule
